FILE: hdl/lcd_pkg.sv
// Shared types and constants of the lightmap coverage dilation unit.
// Used by the top level, front end, back end, divider and testbench; depends on nothing else.

package lcd_pkg;

	localparam int MAX_WIDTH_DEF = 32;
	localparam int MAX_HEIGHT    = 4096;
	localparam int COL_W         = 6;
	localparam int ROW_W         = 12;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 13;
	localparam int REGW_W        = 6;
	localparam int REGH_W        = 13;
	localparam int SC_W          = 15;
	localparam int NUM_W         = 25;
	localparam int DEN_W         = 17;
	localparam int QUO_W         = 8;
	localparam int CMDQ_DEPTH    = 4;
	localparam int OUTQ_DEPTH    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

	localparam logic [7:0] EDGE_WEIGHT = 8'd255;

	typedef struct packed {
		logic [6:0] cov;
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
	} texel_t;

	typedef struct packed {
		logic             en;
		logic [1:0]       slot;
		logic [COL_W-1:0] col;
		texel_t           data;
	} mem_wr_t;

	typedef struct packed {
		logic [COL_W-1:0] dx;
		logic [1:0]       up_slot;
		logic [1:0]       mid_slot;
		logic [1:0]       down_slot;
		logic             has_up;
		logic             has_down;
		logic             has_left;
		logic             has_right;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       filled;
		logic       last;
	} res_t;

	// Row slots rotate through three lines of the store.
	function automatic logic [1:0] slot_add(input logic [1:0] s, input logic [1:0] k);
		logic [2:0] t;
		t = {1'b0, s} + {1'b0, k};
		return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
	endfunction

endpackage

FILE: hdl/lightmap_coverage_dilation_unit.sv
// Lightmap coverage dilation: fills uncovered texels from a weighted 3x3 window.
// A texel that releases no result does not hold up the next request; otherwise the next request
// waits while each result goes through pop, 9 store reads, drain, decide and push, and through the
// 8-bit divider if filled; up to 4 results per texel, longer while pop is held low.
// Results lag the input by one row; the last texel flushes the final row. Asynchronous
// active-low reset empties both queues, restarts the frame and sets width and height to 32.

module lightmap_coverage_dilation_unit #(
	parameter int MAX_WIDTH = lcd_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [lcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lcd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           push,
	output logic                           full,
	input  logic [7:0]                     red_in,
	input  logic [7:0]                     green_in,
	input  logic [7:0]                     blue_in,
	input  logic [7:0]                     coverage_raw,
	output logic                           empty,
	input  logic                           pop,
	output logic [7:0]                     red_out,
	output logic [7:0]                     green_out,
	output logic [7:0]                     blue_out,
	output logic                           was_filled,
	output logic                           frame_last
);
	lcd_pkg::texel_t  texel;
	lcd_pkg::mem_wr_t mem_wr;
	lcd_pkg::cmd_t    cmd_in, cmd_out;
	lcd_pkg::res_t    res_in, res_out;
	logic cmd_push, cmdq_full, cmdq_empty, cmd_pop, back_idle, res_push, outq_full;

	assign texel = '{cov: coverage_raw[7:1], b: blue_in, g: green_in, r: red_in};

	lcd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk, .arst_n, .cfg_write, .cfg_index, .cfg_data, .push, .full, .texel,
		.mem_wr, .cmd_push, .cmd(cmd_in), .cmdq_full, .cmdq_empty, .back_idle
	);

	lcd_fifo #(.WIDTH($bits(lcd_pkg::cmd_t)), .DEPTH(lcd_pkg::CMDQ_DEPTH)) u_cmdq (
		.clk, .arst_n, .wr(cmd_push), .wdata(cmd_in), .full(cmdq_full),
		.rd(cmd_pop), .rdata(cmd_out), .empty(cmdq_empty)
	);

	lcd_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk, .arst_n, .mem_wr, .cmd_valid(!cmdq_empty), .cmd_pop, .cmd(cmd_out),
		.res_push, .res(res_in), .res_full(outq_full), .idle(back_idle)
	);

	lcd_fifo #(.WIDTH($bits(lcd_pkg::res_t)), .DEPTH(lcd_pkg::OUTQ_DEPTH)) u_outq (
		.clk, .arst_n, .wr(res_push), .wdata(res_in), .full(outq_full),
		.rd(pop), .rdata(res_out), .empty
	);

	assign red_out    = res_out.r;
	assign green_out  = res_out.g;
	assign blue_out   = res_out.b;
	assign was_filled = res_out.filled;
	assign frame_last = res_out.last;
endmodule

FILE: hdl/lcd_fifo.sv
// Small first-in first-out queue of packed words.
// Used for the command queue and the result queue; no package needed.

module lcd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_rd) rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

FILE: hdl/lcd_front.sv
// Front end: configuration registers, raster counters, texel store writes
// and generation of the fill commands for each texel. Uses lcd_pkg.

module lcd_front #(
	parameter int MAX_WIDTH = lcd_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [lcd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lcd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           push,
	output logic                           full,
	input  lcd_pkg::texel_t                texel,
	output lcd_pkg::mem_wr_t               mem_wr,
	output logic                           cmd_push,
	output lcd_pkg::cmd_t                  cmd,
	input  logic                           cmdq_full,
	input  logic                           cmdq_empty,
	input  logic                           back_idle
);
	localparam int CW = lcd_pkg::COL_W;
	localparam int RW = lcd_pkg::ROW_W;

	logic [lcd_pkg::REGW_W-1:0] width_q;
	logic [lcd_pkg::REGH_W-1:0] height_q;
	logic [CW-1:0] col_q, x_q, x, w_eff, dx;
	logic [RW-1:0] row_q, y;
	logic [lcd_pkg::REGH_W-1:0] h_eff;
	logic [1:0] slot_q, s_q, s;
	logic [3:0] pend_q, sel;
	logic yge1_q, yge2_q, restart, accept, xlast, ylast, lower;

	always_comb begin
		if (width_q == '0) w_eff = CW'(1);
		else if (width_q > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
		else w_eff = CW'(width_q);
		if (height_q == '0) h_eff = lcd_pkg::REGH_W'(1);
		else if (height_q > lcd_pkg::MAX_HEIGHT) h_eff = lcd_pkg::REGH_W'(lcd_pkg::MAX_HEIGHT);
		else h_eff = height_q;
	end

	assign restart = (col_q >= w_eff) || ({1'b0, row_q} >= h_eff);
	assign x       = restart ? '0 : col_q;
	assign y       = restart ? '0 : row_q;
	assign s       = restart ? '0 : slot_q;
	assign xlast   = (x == w_eff - 1'b1);
	assign ylast   = ({1'b0, y} == h_eff - 1'b1);
	assign full    = (pend_q != '0) || !cmdq_empty || !back_idle;
	assign accept  = push && !full;

	assign mem_wr.en   = accept;
	assign mem_wr.slot = s;
	assign mem_wr.col  = x;
	assign mem_wr.data = texel;

	// Commands go out oldest first: row above, then the last row's own texels.
	always_comb begin
		sel = '0;
		priority if (pend_q[0]) sel[0] = 1'b1;
		else if (pend_q[1]) sel[1] = 1'b1;
		else if (pend_q[2]) sel[2] = 1'b1;
		else if (pend_q[3]) sel[3] = 1'b1;
		else sel = '0;
	end

	assign lower = sel[0] || sel[1];
	assign dx    = (sel[0] || sel[2]) ? x_q - 1'b1 : w_eff - 1'b1;

	always_comb begin
		cmd.dx        = dx;
		cmd.up_slot   = lower ? lcd_pkg::slot_add(s_q, 2'd1) : lcd_pkg::slot_add(s_q, 2'd2);
		cmd.mid_slot  = lower ? lcd_pkg::slot_add(s_q, 2'd2) : s_q;
		cmd.down_slot = s_q;
		cmd.has_up    = lower ? yge2_q : yge1_q;
		cmd.has_down  = lower;
		cmd.has_left  = (dx != '0);
		cmd.has_right = (dx != w_eff - 1'b1);
		cmd.last      = sel[3];
	end

	assign cmd_push = (pend_q != '0) && !cmdq_full;

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= x;
			s_q    <= s;
			yge1_q <= (y >= RW'(1));
			yge2_q <= (y >= RW'(2));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lcd_pkg::REGW_W'(32);
			height_q <= lcd_pkg::REGH_W'(32);
			col_q    <= '0;
			row_q    <= '0;
			slot_q   <= '0;
			pend_q   <= '0;
		end else begin
			if (cmd_push) pend_q <= pend_q & ~sel;
			if (cfg_write && cfg_index == lcd_pkg::REG_WIDTH) begin
				width_q <= cfg_data[lcd_pkg::REGW_W-1:0];
				col_q <= '0;
				row_q <= '0;
				slot_q <= '0;
			end else if (cfg_write && cfg_index == lcd_pkg::REG_HEIGHT) begin
				height_q <= cfg_data;
				col_q <= '0;
				row_q <= '0;
				slot_q <= '0;
			end else if (accept) begin
				pend_q <= {ylast && xlast, ylast && (x != '0),
					(y != '0) && xlast, (y != '0) && (x != '0)};
				if (xlast) begin
					col_q <= '0;
					if (ylast) begin
						row_q  <= '0;
						slot_q <= '0;
					end else begin
						row_q  <= y + 1'b1;
						slot_q <= lcd_pkg::slot_add(s, 2'd1);
					end
				end else begin
					col_q <= x + 1'b1;
					row_q <= y;
					slot_q <= s;
				end
			end
		end
	end
endmodule

FILE: hdl/lcd_div.sv
// Restoring divider, one quotient bit per cycle, for one colour channel.
// Uses lcd_pkg for operand widths.

module lcd_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [lcd_pkg::NUM_W-1:0] num,
	input  logic [lcd_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [lcd_pkg::QUO_W-1:0] quo
);
	localparam int NW = lcd_pkg::NUM_W;
	localparam int QW = lcd_pkg::QUO_W;
	localparam int KW = $clog2(QW);

	logic [NW-1:0] rem_q, dsh_q;
	logic [QW-1:0] quo_q;
	logic [KW-1:0] cnt_q;
	logic busy_q, done_q, ge;

	assign ge   = (rem_q >= dsh_q);
	assign done = done_q;
	assign quo  = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= NW'(den) << (QW - 1);
		end else if (busy_q) begin
			if (ge) rem_q <= rem_q - dsh_q;
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == KW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

FILE: hdl/lcd_back.sv
// Back end: texel store, neighbourhood read and weighted accumulation,
// division and result hand-off. Uses lcd_pkg and lcd_div.

module lcd_back #(
	parameter int MAX_WIDTH = lcd_pkg::MAX_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  lcd_pkg::mem_wr_t mem_wr,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	input  lcd_pkg::cmd_t    cmd,
	output logic             res_push,
	output lcd_pkg::res_t    res,
	input  logic             res_full,
	output logic             idle
);
	localparam int DEPTH = 3 * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = lcd_pkg::COL_W;
	localparam int SW    = lcd_pkg::SC_W;
	localparam int NW    = lcd_pkg::NUM_W;
	localparam int DW    = lcd_pkg::DEN_W;
	localparam int QW    = lcd_pkg::QUO_W;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_READ   = 6'b000010,
		ST_DRAIN  = 6'b000100,
		ST_DECIDE = 6'b001000,
		ST_DIVIDE = 6'b010000,
		ST_PUSH   = 6'b100000
	} state_t;

	typedef struct packed {
		logic valid;
		logic edge_w;
		logic centre;
	} tag_t;

	lcd_pkg::texel_t mem_q [DEPTH];
	lcd_pkg::texel_t rd_s1, centre_q;
	state_t state_q;
	lcd_pkg::cmd_t cmd_q;
	lcd_pkg::res_t res_q;
	tag_t tag_s1, tag_s2, tag_s3, tag_now;
	logic [1:0] pr_q, pc_q, drain_q, slot;
	logic [CW-1:0] col;
	logic [AW-1:0] wa, ra;
	logic [SW-1:0] sc_s2, sc_s3;
	logic [7:0] r_s2, g_s2, b_s2;
	logic [NW-1:0] pr_s3, pg_s3, pb_s3, acc_r_q, acc_g_q, acc_b_q;
	logic [DW-1:0] den_q;
	logic inrange, rd_en, div_start;
	logic [2:0] div_done;
	logic [QW-1:0] q_r, q_g, q_b;

	assign wa = AW'(mem_wr.slot * MAX_WIDTH) + AW'(mem_wr.col);

	// Position in the 3x3 window: rows up/mid/down, columns left/centre/right.
	always_comb begin
		inrange = (pr_q != 2'd0 || cmd_q.has_up) && (pr_q != 2'd2 || cmd_q.has_down) &&
			(pc_q != 2'd0 || cmd_q.has_left) && (pc_q != 2'd2 || cmd_q.has_right);
		unique case (pr_q)
			2'd0: slot = cmd_q.up_slot;
			2'd2: slot = cmd_q.down_slot;
			default: slot = cmd_q.mid_slot;
		endcase
		if (!inrange) col = cmd_q.dx;
		else if (pc_q == 2'd0) col = cmd_q.dx - 1'b1;
		else if (pc_q == 2'd2) col = cmd_q.dx + 1'b1;
		else col = cmd_q.dx;
		tag_now.centre = (state_q == ST_READ) && (pr_q == 2'd1) && (pc_q == 2'd1);
		tag_now.valid  = (state_q == ST_READ) && inrange && !tag_now.centre;
		tag_now.edge_w = (pr_q == 2'd1) || (pc_q == 2'd1);
	end

	assign ra    = AW'(slot * MAX_WIDTH) + AW'(col);
	assign rd_en = (state_q == ST_READ);

	always_ff @(posedge clk) begin
		if (mem_wr.en) mem_q[wa] <= mem_wr.data;
		if (rd_en) rd_s1 <= mem_q[ra];
	end

	// Weight, then product, then accumulate, one register between each.
	always_ff @(posedge clk) begin
		sc_s2 <= tag_s1.edge_w ? SW'(rd_s1.cov) * SW'(lcd_pkg::EDGE_WEIGHT) : SW'(rd_s1.cov);
		r_s2  <= rd_s1.r;
		g_s2  <= rd_s1.g;
		b_s2  <= rd_s1.b;
		pr_s3 <= NW'(r_s2) * NW'(sc_s2);
		pg_s3 <= NW'(g_s2) * NW'(sc_s2);
		pb_s3 <= NW'(b_s2) * NW'(sc_s2);
		sc_s3 <= sc_s2;
		if (tag_s1.centre) centre_q <= rd_s1;
		if (state_q == ST_IDLE) begin
			acc_r_q <= '0;
			acc_g_q <= '0;
			acc_b_q <= '0;
			den_q   <= '0;
		end else if (tag_s3.valid) begin
			acc_r_q <= acc_r_q + pr_s3;
			acc_g_q <= acc_g_q + pg_s3;
			acc_b_q <= acc_b_q + pb_s3;
			den_q   <= den_q + DW'(sc_s3);
		end
		if (cmd_pop) cmd_q <= cmd;
		if (state_q == ST_DECIDE)
			res_q <= '{r: centre_q.r, g: centre_q.g, b: centre_q.b, filled: 1'b0,
				last: cmd_q.last};
		else if (state_q == ST_DIVIDE && (&div_done))
			res_q <= '{r: q_r, g: q_g, b: q_b, filled: 1'b1, last: cmd_q.last};
	end

	assign div_start = (state_q == ST_DECIDE) && (centre_q.cov == '0) && (den_q != '0);

	lcd_div u_div_r (.clk, .arst_n, .start(div_start), .num(acc_r_q), .den(den_q),
		.done(div_done[0]), .quo(q_r));
	lcd_div u_div_g (.clk, .arst_n, .start(div_start), .num(acc_g_q), .den(den_q),
		.done(div_done[1]), .quo(q_g));
	lcd_div u_div_b (.clk, .arst_n, .start(div_start), .num(acc_b_q), .den(den_q),
		.done(div_done[2]), .quo(q_b));

	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	assign res_push = (state_q == ST_PUSH) && !res_full;
	assign res      = res_q;
	assign idle     = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pr_q    <= '0;
			pc_q    <= '0;
			drain_q <= '0;
			tag_s1  <= '0;
			tag_s2  <= '0;
			tag_s3  <= '0;
		end else begin
			tag_s1 <= tag_now;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						pr_q    <= '0;
						pc_q    <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (pc_q == 2'd2) begin
						pc_q <= '0;
						pr_q <= pr_q + 1'b1;
						if (pr_q == 2'd2) begin
							drain_q <= '0;
							state_q <= ST_DRAIN;
						end
					end else begin
						pc_q <= pc_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == 2'd2) state_q <= ST_DECIDE;
				end
				ST_DECIDE: state_q <= div_start ? ST_DIVIDE : ST_PUSH;
				ST_DIVIDE: if (&div_done) state_q <= ST_PUSH;
				ST_PUSH: if (!res_full) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: hdl/lcd_checker.sv
// Port-level checks for the lightmap coverage dilation unit, bound to its top level.
// Needs no package; sees only cfg_write and the handshake and result ports.

module lcd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_write,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] red_out,
	input logic [7:0] green_out,
	input logic [7:0] blue_out,
	input logic       was_filled,
	input logic       frame_last
);
	// Straight out of reset both sides must be quiet and ready.
	a_reset_state: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> (empty && !full))
		else $error("queues not clear after reset");

	// A request taken into an empty block cannot produce a result on the next cycle.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && empty && !cfg_write) |=> empty)
		else $error("result appeared too soon after a request");

	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("waiting result was lost");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=>
		$stable({red_out, green_out, blue_out, was_filled, frame_last}))
		else $error("waiting result changed");
endmodule

bind lightmap_coverage_dilation_unit lcd_checker u_lcd_checker (.*);

FILE: verif/tb.sv
// Self-checking testbench for lightmap_coverage_dilation_unit: streams texel frames,
// predicts the dilated texels and compares every result. Depends on hdl/lcd_pkg.sv.
`timescale 1ns / 100ps

module tb;
	localparam int STORE_W = 32;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_write = 1'b0;
	logic [lcd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [lcd_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           push = 1'b0;
	logic                           full;
	logic [7:0]            red_in = '0, green_in = '0, blue_in = '0, coverage_raw = '0;
	logic                           empty;
	logic                           pop = 1'b0;
	logic [7:0]                     red_out, green_out, blue_out;
	logic                           was_filled, frame_last;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] c;
	} raw_texel_t;

	raw_texel_t      pending_texels[$];
	lcd_pkg::res_t   dilated_expected[$];
	lcd_pkg::texel_t line_store[3*STORE_W];
	int         col_pos, row_pos, row_slot;
	logic [lcd_pkg::REGW_W-1:0] width_reg;
	logic [lcd_pkg::REGH_W-1:0] height_reg;
	int         texels_sent, results_seen, mismatches, phases_run;

	always #4 clk = ~clk;

	lightmap_coverage_dilation_unit dut (.*);

	function automatic int frame_width();
		if (width_reg < 1) return 1;
		if (width_reg > STORE_W) return STORE_W;
		return int'(width_reg);
	endfunction

	function automatic int frame_height();
		if (height_reg < 1) return 1;
		if (height_reg > lcd_pkg::MAX_HEIGHT) return lcd_pkg::MAX_HEIGHT;
		return int'(height_reg);
	endfunction

	function automatic lcd_pkg::texel_t stored_texel(int rows_up, int col);
		int s;
		s = (row_slot + 3 - (rows_up % 3)) % 3;
		return line_store[s*STORE_W + col];
	endfunction

	// Weighted fill of texel (dy,dx) while row cy is the newest row in the store.
	task automatic release_texel(int cy, int dy, int dx, int w, int h, bit last);
		lcd_pkg::texel_t t, s;
		lcd_pkg::res_t   res;
		longint  sr, sg, sb, den, sc;
		int      y0, y1, x0, x1;
		t = stored_texel(cy - dy, dx);
		res.r = t.r; res.g = t.g; res.b = t.b; res.filled = 1'b0; res.last = last;
		if (t.cov == 0) begin
			sr = 0; sg = 0; sb = 0; den = 0;
			y0 = (dy > 0) ? dy - 1 : 0;
			y1 = (dy + 1 < h) ? dy + 1 : h - 1;
			x0 = (dx > 0) ? dx - 1 : 0;
			x1 = (dx + 1 < w) ? dx + 1 : w - 1;
			for (int sy = y0; sy <= y1; sy++) begin
				for (int sx = x0; sx <= x1; sx++) begin
					if (sy == dy && sx == dx) continue;
					s = stored_texel(cy - sy, sx);
					if (s.cov == 0) continue;
					sc = longint'(s.cov) * ((sy == dy || sx == dx) ? 255 : 1);
					sr += longint'(s.r) * sc;
					sg += longint'(s.g) * sc;
					sb += longint'(s.b) * sc;
					den += sc;
				end
			end
			if (den != 0) begin
				res.r = 8'(sr / den); res.g = 8'(sg / den); res.b = 8'(sb / den);
				res.filled = 1'b1;
			end
		end
		dilated_expected.push_back(res);
	endtask

	task automatic take_texel(raw_texel_t in);
		int w, h, x, y;
		w = frame_width();
		h = frame_height();
		if (col_pos >= w || row_pos >= h) begin
			col_pos = 0; row_pos = 0; row_slot = 0;
		end
		x = col_pos;
		y = row_pos;
		line_store[row_slot*STORE_W + x] = '{cov: in.c[7:1], b: in.b, g: in.g, r: in.r};
		if (y >= 1) begin
			if (x >= 1) release_texel(y, y - 1, x - 1, w, h, 1'b0);
			if (x == w - 1) release_texel(y, y - 1, w - 1, w, h, 1'b0);
		end
		if (y == h - 1) begin
			if (x >= 1) release_texel(y, y, x - 1, w, h, 1'b0);
			if (x == w - 1) release_texel(y, y, w - 1, w, h, 1'b1);
		end
		if (x + 1 >= w) begin
			col_pos = 0;
			if (y + 1 >= h) begin
				row_pos = 0; row_slot = 0;
			end else begin
				row_pos = y + 1; row_slot = (row_slot + 1) % 3;
			end
		end else begin
			col_pos = x + 1;
		end
	endtask

	// Requests accepted on this edge update the predictor.
	always @(posedge clk) begin
		if (arst_n && cfg_write) begin
			if (cfg_index == lcd_pkg::REG_WIDTH)
				width_reg = cfg_data[lcd_pkg::REGW_W-1:0];
			else if (cfg_index == lcd_pkg::REG_HEIGHT)
				height_reg = cfg_data[lcd_pkg::REGH_W-1:0];
			if (cfg_index == lcd_pkg::REG_WIDTH || cfg_index == lcd_pkg::REG_HEIGHT) begin
				col_pos = 0; row_pos = 0; row_slot = 0;
			end
		end
		if (arst_n && push && !full) begin
			take_texel(pending_texels.pop_front());
			texels_sent++;
		end
	end

	always @(negedge clk) begin
		bit gap;
		gap = ($urandom_range(0, 99) < 26) && !(texels_sent >= 40 && texels_sent < 75);
		if (arst_n && pending_texels.size() > 0 && !gap) begin
			push <= 1'b1;
			{red_in, green_in, blue_in, coverage_raw} <= pending_texels[0];
		end else begin
			push <= 1'b0;
		end
	end

	always @(negedge clk) begin
		pop <= ($urandom_range(0, 99) >= 26) || (results_seen >= 30 && results_seen < 60);
	end

	task automatic report(string field, int want, int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		lcd_pkg::res_t want;
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (dilated_expected.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing expected, got r=%0d g=%0d b=%0d", $time,
					red_out, green_out, blue_out);
			end else begin
				want = dilated_expected.pop_front();
				report("red", want.r, red_out);
				report("green", want.g, green_out);
				report("blue", want.b, blue_out);
				report("filled", want.filled, was_filled);
				report("frame_last", want.last, frame_last);
			end
		end
	end

	task automatic settle();
		do @(negedge clk);
		while (pending_texels.size() > 0 || dilated_expected.size() > 0);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_reg(logic [lcd_pkg::CFG_IDX_W-1:0] idx, int value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[lcd_pkg::CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic next_phase(int w, int h);
		settle();
		write_reg(lcd_pkg::REG_WIDTH, w);
		write_reg(lcd_pkg::REG_HEIGHT, h);
		phases_run++;
	endtask

	function automatic raw_texel_t random_texel();
		raw_texel_t t;
		t = $urandom;
		// Raw coverage of one also halves to uncovered.
		if ($urandom_range(0, 99) < 45) t.c = 8'($urandom_range(0, 1));
		return t;
	endfunction

	initial begin
		int w, h;
		width_reg = 6'd32; height_reg = 13'd32;
		col_pos = 0; row_pos = 0; row_slot = 0;
		for (int i = 0; i < 3*STORE_W; i++) line_store[i] = '0;
		texels_sent = 0; results_seen = 0; mismatches = 0; phases_run = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset size: part of a frame, later dropped by a register write.
		for (int i = 0; i < 12; i++) pending_texels.push_back(random_texel());

		// Zero sizes act as one texel per frame.
		next_phase(0, 0);
		pending_texels.push_back('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
		pending_texels.push_back('{8'h00, 8'h00, 8'h00, 8'h00});
		pending_texels.push_back('{8'hA5, 8'h5A, 8'h0F, 8'h01});

		// 3x3: centre filled from edges and corners, then an all-uncovered frame.
		next_phase(3, 3);
		pending_texels.push_back('{8'hFF, 8'h00, 8'h80, 8'h03});
		pending_texels.push_back('{8'h00, 8'hFF, 8'h01, 8'hFE});
		pending_texels.push_back('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
		pending_texels.push_back('{8'h10, 8'h20, 8'h30, 8'h02});
		pending_texels.push_back('{8'h77, 8'h77, 8'h77, 8'h00});
		pending_texels.push_back('{8'h00, 8'h00, 8'h00, 8'h01});
		pending_texels.push_back('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
		pending_texels.push_back('{8'h00, 8'h00, 8'h00, 8'h00});
		pending_texels.push_back('{8'h01, 8'h02, 8'h03, 8'h80});
		for (int i = 0; i < 9; i++) pending_texels.push_back('{8'h40, 8'h41, 8'h42, 8'h01});

		// Oversized width acts as the widest row; oversized height as the tallest frame.
		next_phase(63, 8191);
		for (int i = 0; i < 36; i++) pending_texels.push_back(random_texel());

		// An index beyond the register list is ignored.
		settle();
		write_reg(2'd3, 'h1FFF);
		next_phase(6, 2);
		for (int i = 0; i < 12; i++) pending_texels.push_back(random_texel());

		next_phase(1, 4096);
		for (int i = 0; i < 5; i++) pending_texels.push_back(random_texel());

		while (texels_sent + pending_texels.size() < 100) begin
			w = $urandom_range(1, 5);
			h = $urandom_range(1, 4);
			next_phase(w, h);
			for (int i = 0; i < w*h; i++) pending_texels.push_back(random_texel());
			// Now and then one more row, a partial frame that the next write drops unless h is 1.
			if ($urandom_range(0, 4) == 0)
				for (int i = 0; i < w; i++) pending_texels.push_back(random_texel());
		end
		settle();

		$display("Covered %0d register settings, %0d texels in, %0d dilated texels out.",
			phases_run, texels_sent, results_seen);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Timed out with %0d results outstanding.", dilated_expected.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
